>>> rtl/core/ppqs_pkg.sv
// Package: shared types, constants and command codes of the quantum scheduler.
package ppqs_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] task_id;
    logic [7:0]  task_priority;
    logic [31:0] arrive_tick;
    logic [15:0] work_ticks;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  slot_index;
    logic        ran;
    logic [15:0] run_id;
    logic [7:0]  run_priority;
    logic [15:0] run_remaining;
    logic        completed;
    logic [31:0] finish_tick;
    logic [31:0] wait_total;
    logic [4:0]  ready_length;
    logic        all_done;
    logic [31:0] tick_time;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic do_add;     // store task (one cycle)
    logic do_clear;
    logic scan_start; // reset scan pointer
    logic scan_step;  // examine one slot for arrival
    logic sel;        // reselection step
    logic sel_again;  // pick a task only if none runs (after a reinsert)
    logic run;        // run step and wait update
    logic finish;     // emit result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic ins_busy;
  } dp_sts_t;

endpackage

>>> rtl/core/ppqs_datapath.sv
// Datapath: task table, sorted ready list, counters and result assembly.
module ppqs_datapath
  import ppqs_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CW = $clog2(MAX_TASKS + 1)
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  logic [7:0] quantum,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_word_t out_word
);

  logic [15:0] id_r   [MAX_TASKS];
  logic [7:0]  pri_r  [MAX_TASKS];
  logic [31:0] arr_r  [MAX_TASKS];
  logic [15:0] rem_r  [MAX_TASKS];
  logic        arrd_r [MAX_TASKS];
  logic [31:0] wait_r [MAX_TASKS];
  logic [SW-1:0] ord_r [MAX_TASKS];

  logic [CW-1:0] stored_r, ready_r;
  logic [31:0]   now_r;
  logic          rv_r;
  logic [SW-1:0] rs_r;
  logic [7:0]    qu_r;
  logic [CW-1:0] scan_r;
  out_word_t     res_r, res_nxt;

  // Pending insert: a slot waiting to be placed (one list shift per cycle).
  logic          ins_v_r;
  logic [SW-1:0] ins_s_r;

  logic [SW-1:0] scan_s;
  assign scan_s = scan_r[SW-1:0];
  assign sts.scan_last = (scan_r >= stored_r);
  assign sts.ins_busy  = ins_v_r;

  function automatic logic key_less(input logic [7:0] pa, input logic [15:0] ia,
                                    input logic [7:0] pb, input logic [15:0] ib);
    key_less = (pa != pb) ? (pa < pb) : (ia < ib);
  endfunction

  // Insert position: first entry whose key is strictly larger than the new one.
  logic [CW-1:0] pos;
  always_comb begin
    pos = ready_r;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      if (CW'(k) < ready_r &&
          key_less(pri_r[ins_s_r], id_r[ins_s_r], pri_r[ord_r[k]], id_r[ord_r[k]]))
        pos = CW'(k);
    end
  end

  logic all_done;
  always_comb begin
    all_done = 1'b1;
    for (int k = 0; k < MAX_TASKS; k++)
      if (CW'(k) < stored_r && rem_r[k] != 16'd0) all_done = 1'b0;
  end

  logic reselect;
  logic head_less;
  assign head_less = (ready_r != '0) &&
                     key_less(pri_r[ord_r[0]], id_r[ord_r[0]], pri_r[rs_r], id_r[rs_r]);
  assign reselect = !rv_r || head_less || (qu_r >= quantum);

  logic [15:0] rem_run;
  assign rem_run = rem_r[rs_r];

  logic add_ok;
  assign add_ok = (stored_r < CW'(MAX_TASKS)) && in_word.work_ticks != 16'd0;

  // Result word: add status is latched at accept, tick results at the run step.
  always_comb begin
    res_nxt = res_r;
    if (cmd.scan_start) begin
      res_nxt = '0;
      if (cmd.do_add && add_ok) begin
        res_nxt.accepted   = 1'b1;
        res_nxt.slot_index = 4'(stored_r);
      end
    end else if (cmd.run) begin
      res_nxt = '0;
      res_nxt.tick_time = now_r;
      if (rv_r) begin
        res_nxt.ran           = 1'b1;
        res_nxt.run_id        = id_r[rs_r];
        res_nxt.run_priority  = pri_r[rs_r];
        res_nxt.run_remaining = rem_run;
        if (rem_run == 16'd1) begin
          res_nxt.completed   = 1'b1;
          res_nxt.finish_tick = now_r + 32'd1;
          res_nxt.wait_total  = wait_r[rs_r];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_r <= '0;
    else res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.do_clear) begin
      stored_r <= '0;
      ready_r  <= '0;
      now_r    <= '0;
      rv_r     <= 1'b0;
      rs_r     <= '0;
      qu_r     <= '0;
      scan_r   <= '0;
      ins_v_r  <= 1'b0;
    end else begin
      if (cmd.do_add && add_ok) begin
        id_r[stored_r[SW-1:0]]   <= in_word.task_id;
        pri_r[stored_r[SW-1:0]]  <= in_word.task_priority;
        arr_r[stored_r[SW-1:0]]  <= in_word.arrive_tick;
        rem_r[stored_r[SW-1:0]]  <= in_word.work_ticks;
        arrd_r[stored_r[SW-1:0]] <= 1'b0;
        wait_r[stored_r[SW-1:0]] <= '0;
        stored_r <= stored_r + 1'b1;
      end
      if (cmd.scan_start) scan_r <= '0;
      if (ins_v_r) begin
        // shift tail up and place
        for (int k = MAX_TASKS - 1; k > 0; k--)
          if (CW'(k) > pos && CW'(k) <= ready_r) ord_r[k] <= ord_r[k-1];
        ord_r[pos[SW-1:0]] <= ins_s_r;
        ready_r <= ready_r + 1'b1;
        ins_v_r <= 1'b0;
      end else if (cmd.scan_step && !sts.scan_last) begin
        if (!arrd_r[scan_s] && arr_r[scan_s] <= now_r && rem_r[scan_s] != 16'd0) begin
          arrd_r[scan_s] <= 1'b1;
          ins_v_r <= 1'b1;
          ins_s_r <= scan_s;
        end
        scan_r <= scan_r + 1'b1;
      end else if (cmd.sel || (cmd.sel_again && !rv_r)) begin
        // second pass only picks the head once a preempted task has landed
        if (reselect) begin
          qu_r <= '0;
          if (rv_r && rem_run != 16'd0) begin
            // reinsert preempted task; selection repeats after it lands
            ins_v_r <= 1'b1;
            ins_s_r <= rs_r;
            rv_r    <= 1'b0;
          end else if (ready_r != '0) begin
            rs_r <= ord_r[0];
            rv_r <= 1'b1;
            for (int k = 0; k < MAX_TASKS - 1; k++) ord_r[k] <= ord_r[k+1];
            ready_r <= ready_r - 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
        end
      end else if (cmd.run) begin
        now_r <= now_r + 32'd1;
        if (rv_r) begin
          rem_r[rs_r] <= rem_run - 16'd1;
          for (int k = 0; k < MAX_TASKS; k++)
            if (CW'(k) < stored_r && SW'(k) != rs_r && arrd_r[k] && rem_r[k] != 16'd0 &&
                wait_r[k] != 32'hFFFF_FFFF)
              wait_r[k] <= wait_r[k] + 32'd1;
          if (rem_run == 16'd1) begin
            rv_r <= 1'b0;
            qu_r <= '0;
          end else if (qu_r != 8'hFF) begin
            qu_r <= qu_r + 8'd1;
          end
        end
      end
    end
  end

  always_comb begin
    out_word = '0;
    if (cmd.finish) out_word = res_r;
    out_word.ready_length = 5'(ready_r);
    out_word.all_done     = all_done;
  end

endmodule

>>> rtl/core/ppqs_ctrl.sv
// Controller: sequences add, tick scan, selection, run and clear.
module ppqs_ctrl
  import ppqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_word_t in_word,
  input  dp_sts_t  sts,
  output logic     busy,
  output dp_cmd_t  cmd,
  output logic     out_valid
);

  typedef enum logic [2:0] {S_IDLE, S_POST, S_SCAN, S_SEL, S_SEL2, S_RUN, S_DONE}
    state_t;
  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          case (cmd_t'(in_word.command))
            CMD_TICK: state_r <= S_SCAN;
            default:  state_r <= S_POST;
          endcase
        end
        S_POST: state_r <= S_IDLE;
        S_SCAN: if (sts.scan_last && !sts.ins_busy) state_r <= S_SEL;
        S_SEL:  if (!sts.ins_busy) state_r <= S_SEL2;
        S_SEL2: if (!sts.ins_busy) state_r <= S_RUN;
        S_RUN:  state_r <= S_DONE;
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  always_comb begin
    cmd = '0;
    cmd.do_add     = (state_r == S_IDLE) && start && (in_word.command == CMD_ADD);
    cmd.do_clear   = (state_r == S_IDLE) && start && (in_word.command == CMD_CLEAR);
    cmd.scan_start = (state_r == S_IDLE) && start;
    cmd.scan_step  = (state_r == S_SCAN);
    cmd.sel        = (state_r == S_SEL);
    cmd.sel_again  = (state_r == S_SEL2);
    cmd.run        = (state_r == S_RUN);
    cmd.finish     = (state_r == S_DONE) || (state_r == S_POST);
  end
  assign out_valid = (state_r == S_DONE) || (state_r == S_POST);

endmodule

>>> rtl/core/preemptive_priority_quantum_scheduler.sv
// Top level: preemptive priority scheduler with time quantum.
//  channel | handshake             | payload
//  in      | start / busy          | in_word (in_word_t)
//  out     | out_valid strobe      | out_word (out_word_t)
//  cfg     | cfg_valid / cfg_ready | cfg_quantum
// Add, clear and no-op pass through S_POST, which holds busy and shows the
// result word. A tick runs S_SCAN, S_SEL, S_SEL2, S_RUN, S_DONE; the scan
// takes one slot per cycle when no list insert (an arrival or a reinserted
// preempted task) is pending. The next word is taken in the first idle cycle.
// rst_n is synchronous; quantum resets to 2. The receiver cannot stall: the
// result word is shown for one cycle.
module preemptive_priority_quantum_scheduler
  import ppqs_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_word_t   in_word,
  output logic       out_valid,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_quantum
);

  logic [7:0] quantum_r;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) quantum_r <= QUANTUM_RESET;
    else if (cfg_valid) quantum_r <= cfg_quantum;
  end

  ppqs_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_word, .sts, .busy, .cmd, .out_valid
  );

  ppqs_datapath #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk, .rst_n, .in_word, .quantum(quantum_r), .cmd, .sts, .out_word
  );

endmodule

>>> rtl/core/ppqs_checker.sv
// Checker: port-level properties of the scheduler, bound to the top level.
module ppqs_checker
  import ppqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accept");
  a_ran_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.completed |-> out_word.ran) else $error("completion without run");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.ready_length <= 5'd16) else $error("list length");
endmodule

bind preemptive_priority_quantum_scheduler ppqs_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_word
);
